// ----- rtl/multi_pin_shift_debouncer_assert.svh -----
// Assertion macros for the checker module.
`ifndef MULTI_PIN_SHIFT_DEBOUNCER_ASSERT_SVH
`define MULTI_PIN_SHIFT_DEBOUNCER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define MPSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("multi_pin_shift_debouncer: assertion failed");

// Checked on every clock edge, reset included.
`define MPSD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("multi_pin_shift_debouncer: assertion failed");

`endif

// ----- rtl/mpsd_pkg.sv -----
package mpsd_pkg;

  localparam int HIST_W = 8;
  localparam int CNT_W  = 8;
  localparam int PIN_W  = 4;
  localparam int CH_W   = 4;
  localparam int MASK_W = 4;

  localparam logic [HIST_W-1:0] HIST_ALL_ONES  = 8'hff;
  localparam logic [HIST_W-1:0] HIST_ALL_ZEROS = 8'h00;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_MASK   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_MASK  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [PIN_W-1:0] pin_levels;
    logic [CH_W-1:0]  channel_number;
  } in_t;

  typedef struct packed {
    kind_e             kind;
    logic [CH_W-1:0]   channel;
    logic              level;
    logic [CNT_W-1:0]  press_count;
    logic [MASK_W-1:0] state_mask;
    logic              last;
  } out_t;

  // Registered state of one lane.
  typedef struct packed {
    logic             level;
    logic [CNT_W-1:0] count;
  } lane_stat_t;

  // What a sample does to one lane, valid in the cycle of the sample.
  typedef struct packed {
    logic             changed;
    logic             level;
    logic [CNT_W-1:0] count;
  } lane_evt_t;

endpackage

// ----- rtl/mpsd_lane.sv -----
module mpsd_lane
  import mpsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sample_i,
  input  logic       active_i,
  input  logic       clear_i,
  output lane_stat_t stat_o,
  output lane_evt_t  evt_o
);

  logic [HIST_W-1:0] history_q, history_d;
  logic              level_q, level_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [HIST_W-1:0] hist_next;
  logic              rise, fall;

  assign hist_next = {history_q[HIST_W-2:0], active_i};
  assign rise      = !level_q && (hist_next == HIST_ALL_ONES);
  assign fall      = level_q && (hist_next == HIST_ALL_ZEROS);

  assign evt_o.changed = rise | fall;
  assign evt_o.level   = level_q ^ (rise | fall);
  assign evt_o.count   = count_q + CNT_W'(rise);

  assign stat_o.level = level_q;
  assign stat_o.count = count_q;

  always_comb begin
    history_d = history_q;
    level_d   = level_q;
    count_d   = count_q;
    if (sample_i) begin
      history_d = hist_next;
      level_d   = evt_o.level;
      count_d   = evt_o.count;
    end else if (clear_i) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      history_q <= '0;
      level_q   <= 1'b0;
      count_q   <= '0;
    end else begin
      history_q <= history_d;
      level_q   <= level_d;
      count_q   <= count_d;
    end
  end

endmodule

// ----- rtl/mpsd_merge.sv -----
// Holds the results of one transaction and hands them out lowest slot first,
// one per cycle while the output is not stalled, through an output register.
module mpsd_merge
  import mpsd_pkg::*;
#(
  parameter int N = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  logic [N-1:0] load_v_i,
  input  out_t         load_d_i [N],
  output logic         load_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_t         out_data_o
);

  logic [N-1:0] pend_v_q, pend_v_d;
  out_t         pend_q [N];
  logic         out_v_q, out_v_d;
  out_t         out_q, out_d;
  logic [N-1:0] pick;
  logic         pop;

  assign pick = pend_v_q & (~pend_v_q + N'(1));
  assign pop  = (pend_v_q != '0) && (!out_v_q || out_ready_i);

  assign load_ready_o = (pend_v_q == '0) || (pop && $onehot(pend_v_q));
  assign out_valid_o  = out_v_q;
  assign out_data_o   = out_q;

  always_comb begin
    out_d = out_q;
    for (int i = 0; i < N; i++) begin
      if (pick[i]) begin
        out_d = pend_q[i];
      end
    end
    out_d.last = (pend_v_q & ~pick) == '0;

    pend_v_d = pop ? (pend_v_q & ~pick) : pend_v_q;
    if (load_i) begin
      pend_v_d = load_v_i;
    end

    out_v_d = out_v_q;
    if (pop) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= '0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pend_q <= load_d_i;
    end
    if (pop) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/multi_pin_shift_debouncer.sv -----
// Debouncer for CHANNELS active-low pins, one lane per pin. A sample
// transaction shifts every pin into its 8-bit history at once and yields one
// change event per channel that flipped, lowest channel first; query and mask
// transactions yield one reply each, and mode 3 yields nothing. Results leave
// through a result buffer and an output register at one per cycle while the
// output is not stalled; a transaction has 0 to CHANNELS results, and the
// next transaction is taken in the cycle the buffer hands out its last
// result. A result passes through the result buffer and then the output
// register before it shows on the output.
module multi_pin_shift_debouncer
  import mpsd_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                accept;
  logic                sample;
  logic                query;
  logic                in_range;
  logic [IDX_W-1:0]    qidx;
  logic [CHANNELS-1:0] active;
  logic [CHANNELS-1:0] clear;
  lane_stat_t          stat [CHANNELS];
  lane_evt_t           evt  [CHANNELS];
  logic [CHANNELS-1:0] load_v;
  out_t                load_d [CHANNELS];
  logic [MASK_W-1:0]   mask;

  assign accept   = in_valid_i && in_ready_o;
  assign sample   = accept && (in_data_i.mode == MODE_SAMPLE);
  assign query    = accept && (in_data_i.mode == MODE_QUERY);
  assign in_range = (in_data_i.channel_number != '0)
                 && (in_data_i.channel_number <= CH_W'(CHANNELS));
  assign qidx     = IDX_W'(in_data_i.channel_number - CH_W'(1));

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    if (i < PIN_W) begin : g_pin
      assign active[i] = ~in_data_i.pin_levels[i];
    end else begin : g_nopin
      assign active[i] = 1'b0;
    end
    assign clear[i] = query && in_range && (qidx == IDX_W'(i));

    mpsd_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sample_i(sample),
      .active_i(active[i]),
      .clear_i (clear[i]),
      .stat_o  (stat[i]),
      .evt_o   (evt[i])
    );
  end

  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < CHANNELS) begin : g_used
      assign mask[b] = stat[b].level;
    end else begin : g_unused
      assign mask[b] = 1'b0;
    end
  end

  always_comb begin
    load_v = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      load_d[i] = '0;
    end
    unique case (in_data_i.mode)
      MODE_SAMPLE: begin
        for (int i = 0; i < CHANNELS; i++) begin
          load_v[i]             = evt[i].changed;
          load_d[i].kind        = KIND_EVENT;
          load_d[i].channel     = CH_W'(i + 1);
          load_d[i].level       = evt[i].level;
          load_d[i].press_count = evt[i].count;
        end
      end
      MODE_QUERY: begin
        load_v[0]         = 1'b1;
        load_d[0].channel = in_data_i.channel_number;
        if (in_range) begin
          load_d[0].kind        = KIND_QUERY;
          load_d[0].level       = stat[qidx].level;
          load_d[0].press_count = stat[qidx].count;
        end else begin
          load_d[0].kind = KIND_ERROR;
        end
      end
      MODE_MASK: begin
        load_v[0]            = 1'b1;
        load_d[0].kind       = KIND_MASK;
        load_d[0].state_mask = mask;
      end
      default: begin
        load_v = '0;
      end
    endcase
  end

  mpsd_merge #(
    .N(CHANNELS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .load_v_i    (load_v),
    .load_d_i    (load_d),
    .load_ready_o(in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/mpsd_check.sv -----
module mpsd_check
  import mpsd_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

`include "multi_pin_shift_debouncer_assert.svh"

  // A stalled result stays put.
  `MPSD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // Replies are single results, so each closes its transaction.
  `MPSD_ASSERT(a_reply_last, out_valid_o && out_data_o.kind != KIND_EVENT |-> out_data_o.last)

  `MPSD_ASSERT(a_mask_fields, out_valid_o && out_data_o.kind == KIND_MASK |-> out_data_o.channel == '0 && !out_data_o.level && out_data_o.press_count == '0)

  `MPSD_ASSERT(a_event_chan, out_valid_o && out_data_o.kind == KIND_EVENT |-> out_data_o.channel != '0 && out_data_o.channel <= CH_W'(CHANNELS) && out_data_o.state_mask == '0)

endmodule

bind multi_pin_shift_debouncer mpsd_check #(.CHANNELS(CHANNELS)) u_mpsd_check (.*);
